// ----- rtl/efmb_pkg.sv -----
// efmb_pkg: shared types, constants and pack/unpack helpers for the
// eight-frame motion blur. No dependencies; imported by every rtl module.
package efmb_pkg;

  // Frame store geometry
  localparam int PIXELS     = 65536;
  localparam int ADDR_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int HIST_DEPTH = 8;
  localparam int SLOT_W     = $clog2(HIST_DEPTH);

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int IDX_W   = 16;
  localparam int RGB_W   = 24;
  localparam int PHASE_W = 3;
  localparam int WORD_W  = 32;

  // Request codes
  localparam logic REQ_NORMAL = 1'b0;
  localparam logic REQ_REINIT = 1'b1;

  // Blur mode codes
  localparam logic MODE_DISCRETE   = 1'b0;
  localparam logic MODE_CONTINUOUS = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_REFRESH = '0;

  // Classified item as it travels from front to back
  typedef struct packed {
    logic               req;
    logic [IDX_W-1:0]   idx;
    logic [RGB_W-1:0]   rgb;
    logic [PHASE_W-1:0] phase;
    logic               idx_ok;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  packed_px;
  } item_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic p1_valid;
    logic fwd_hit;
  } back_stat_t;

  // Widen a pixel: blue at 7:0, green at 18:11, red[7:3] at 28:24
  function automatic logic [WORD_W-1:0] pack_rgb(input logic [RGB_W-1:0] c);
    pack_rgb = {3'b000, c[23:19], 5'b00000, c[15:8], 3'b000, c[7:0]};
  endfunction

  // Average of eight widened words back to byte layout
  function automatic logic [RGB_W-1:0] unpack_sum(input logic [WORD_W-1:0] s);
    unpack_sum = {s[31:24], s[21:14], s[10:3]};
  endfunction

endpackage

// ----- rtl/eight_frame_motion_blur.sv -----
// eight_frame_motion_blur: top level; front classifier, item queue, back end.
// One item per cycle unless output stalls; result via queue, stage 1, out reg.
// Rate set by one read and one write port per frame store, with a one-item
// bypass around the store read. blur_mode resets to discrete; history slot to 0.
// Stores are not cleared by reset: each pixel needs a reinit item before use.
// Depends on efmb_pkg, efmb_front, efmb_queue, efmb_back.
module eight_frame_motion_blur (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_blur_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [efmb_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [efmb_pkg::RGB_W-1:0]    in_pixel_rgb,
  input  logic [efmb_pkg::PHASE_W-1:0]  in_frame_phase,
  input  logic                          in_end_of_frame,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [efmb_pkg::RGB_W-1:0]    out_rgb
);
  import efmb_pkg::*;

  logic       blur_mode_r;
  logic       push;
  item_t      push_item;
  logic       push_ready;
  logic       pop;
  logic       q_valid;
  item_t      q_item;
  back_stat_t stat;

  // Mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_mode_r <= MODE_DISCRETE;
    end else if (cfg_valid) begin
      blur_mode_r <= cfg_blur_mode;
    end
  end

  efmb_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pixel_index  (in_pixel_index),
    .in_pixel_rgb    (in_pixel_rgb),
    .in_frame_phase  (in_frame_phase),
    .in_end_of_frame (in_end_of_frame),
    .push            (push),
    .push_item       (push_item),
    .push_ready      (push_ready)
  );

  efmb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  efmb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .blur_mode (blur_mode_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rgb   (out_rgb),
    .stat      (stat)
  );

  // Back end only takes an item the queue holds
  a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // A waiting item always enters an empty stage 1
  a_stage_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !stat.p1_valid |=> stat.p1_valid)
    else $error("stage 1 left empty with queued item");

  // Bypass flag only stands with an item in stage 1
  a_fwd_with_item: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fwd_hit |-> stat.p1_valid)
    else $error("bypass set without item");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ----- rtl/efmb_front.sv -----
// efmb_front: accepts input items, packs the pixel, range-checks the index
// and tags each item with the current history slot. Depends on efmb_pkg.
module efmb_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [efmb_pkg::IDX_W-1:0]    in_pixel_index,
  input  logic [efmb_pkg::RGB_W-1:0]    in_pixel_rgb,
  input  logic [efmb_pkg::PHASE_W-1:0]  in_frame_phase,
  input  logic                          in_end_of_frame,
  output logic                          push,
  output efmb_pkg::item_t               push_item,
  input  logic                          push_ready
);
  import efmb_pkg::*;

  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  // Classify the item
  always_comb begin
    push_item.req       = in_req_type;
    push_item.idx       = in_pixel_index;
    push_item.rgb       = in_pixel_rgb;
    push_item.phase     = in_frame_phase;
    push_item.idx_ok    = (32'(in_pixel_index) < PIXELS);
    push_item.slot      = slot_r;
    push_item.packed_px = pack_rgb(in_pixel_rgb);
  end

  // History slot: cleared by reinit, advanced at end of frame
  always_comb begin
    slot_nxt = slot_r;
    if (push) begin
      if (in_req_type == REQ_REINIT) begin
        slot_nxt = '0;
      end else if (in_end_of_frame) begin
        slot_nxt = slot_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

// ----- rtl/efmb_queue.sv -----
// efmb_queue: short flip-flop FIFO of classified items between front and
// back. Depends on efmb_pkg.
module efmb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  efmb_pkg::item_t push_item,
  output logic            push_ready,
  input  logic            pop,
  output logic            q_valid,
  output efmb_pkg::item_t q_item
);
  import efmb_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid    = (count_r != '0);
  assign q_item     = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/efmb_back.sv -----
// efmb_back: per-pixel read-modify-write of history, sum and held stores,
// with forwarding between neighboring items, and the output register.
// Depends on efmb_pkg.
module efmb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        blur_mode,
  input  logic                        q_valid,
  input  efmb_pkg::item_t             q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [efmb_pkg::RGB_W-1:0]  out_rgb,
  output efmb_pkg::back_stat_t        stat
);
  import efmb_pkg::*;

  // Frame stores
  logic [WORD_W-1:0] hist_mem [HIST_DEPTH][PIXELS];
  logic [WORD_W-1:0] sum_mem  [PIXELS];
  logic [RGB_W-1:0]  held_mem [PIXELS];

  // Stage 1: item plus registered read data
  logic              p1_valid_r;
  item_t             p1_r;
  logic [WORD_W-1:0] hist_rd_r [HIST_DEPTH];
  logic [WORD_W-1:0] sum_rd_r;
  logic [RGB_W-1:0]  held_rd_r;
  logic              fwd_hit_r;

  // Last write, for an item that read in the same cycle
  logic              last_req_r;
  logic [SLOT_W-1:0] last_slot_r;
  logic [WORD_W-1:0] last_packed_r;
  logic [WORD_W-1:0] last_sum_r;
  logic [RGB_W-1:0]  last_held_r;

  logic              out_valid_r;
  logic [RGB_W-1:0]  out_rgb_r;

  logic              p1_adv;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              same_pixel;
  logic [WORD_W-1:0] hist_old;
  logic [WORD_W-1:0] sum_old;
  logic [RGB_W-1:0]  held_old;
  logic [WORD_W-1:0] sum_new;
  logic [RGB_W-1:0]  held_new;
  logic [RGB_W-1:0]  result;

  // Handshake between stage 1, output register and queue
  assign p1_adv  = p1_valid_r && (!out_valid_r || out_ready);
  assign pop     = q_valid && (!p1_valid_r || p1_adv);
  assign mem_we  = p1_adv && p1_r.idx_ok;
  assign wr_addr = ADDR_W'(p1_r.idx);
  assign rd_addr = ADDR_W'(q_item.idx);
  assign same_pixel = mem_we && q_item.idx_ok && (q_item.idx == p1_r.idx);

  // Old values, bypassing the store when the previous item wrote this pixel
  always_comb begin
    hist_old = hist_rd_r[p1_r.slot];
    sum_old  = sum_rd_r;
    held_old = held_rd_r;
    if (fwd_hit_r) begin
      sum_old  = last_sum_r;
      held_old = last_held_r;
      if (last_req_r == REQ_REINIT || last_slot_r == p1_r.slot) begin
        hist_old = last_packed_r;
      end
    end
  end

  // Blur update
  always_comb begin
    if (p1_r.req == REQ_REINIT) begin
      sum_new  = {p1_r.packed_px[WORD_W-4:0], 3'b000};
      held_new = p1_r.rgb;
      result   = p1_r.rgb;
    end else begin
      sum_new  = sum_old - hist_old + p1_r.packed_px;
      held_new = held_old;
      if (blur_mode == MODE_DISCRETE && p1_r.phase == PHASE_REFRESH) begin
        held_new = unpack_sum(sum_new);
      end
      result = (blur_mode == MODE_CONTINUOUS) ? unpack_sum(sum_new) : held_new;
    end
    if (!p1_r.idx_ok) begin
      result = p1_r.rgb;
    end
  end

  // Store writes and registered reads
  always_ff @(posedge clk) begin
    for (int b = 0; b < HIST_DEPTH; b++) begin
      if (mem_we && (p1_r.req == REQ_REINIT || p1_r.slot == SLOT_W'(b))) begin
        hist_mem[b][wr_addr] <= p1_r.packed_px;
      end
      if (pop) begin
        hist_rd_r[b] <= hist_mem[b][rd_addr];
      end
    end
    if (mem_we) begin
      sum_mem[wr_addr]  <= sum_new;
      held_mem[wr_addr] <= held_new;
    end
    if (pop) begin
      sum_rd_r  <= sum_mem[rd_addr];
      held_rd_r <= held_mem[rd_addr];
    end
  end

  // Stage payload, last-write record and output data
  always_ff @(posedge clk) begin
    if (pop) begin
      p1_r <= q_item;
    end
    if (p1_adv) begin
      last_req_r    <= p1_r.req;
      last_slot_r   <= p1_r.slot;
      last_packed_r <= p1_r.packed_px;
      last_sum_r    <= sum_new;
      last_held_r   <= held_new;
      out_rgb_r     <= result;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        p1_valid_r <= 1'b1;
        fwd_hit_r  <= same_pixel;
      end else if (p1_adv) begin
        p1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
      if (p1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rgb       = out_rgb_r;
  assign stat.p1_valid = p1_valid_r;
  assign stat.fwd_hit  = fwd_hit_r;

endmodule

// ----- tb/sv/tb_eight_frame_motion_blur.sv -----
// tb_eight_frame_motion_blur: self-checking testbench for the eight-frame motion blur.
// It drives pixel items and mode writes, predicts every blurred pixel and checks it.
// Depends on efmb_pkg and eight_frame_motion_blur.
`timescale 1ns / 100ps

module tb_eight_frame_motion_blur;
  import efmb_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PIPE_LAT    = 4;
  localparam int MAX_REPORTS = 10;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_blur_mode;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_req_type;
  logic [IDX_W-1:0]     in_pixel_index;
  logic [RGB_W-1:0]     in_pixel_rgb;
  logic [PHASE_W-1:0]   in_frame_phase;
  logic                 in_end_of_frame;
  logic                 out_valid;
  logic                 out_ready;
  logic [RGB_W-1:0]     out_rgb;

  eight_frame_motion_blur dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_blur_mode   (cfg_blur_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_pixel_index  (in_pixel_index),
    .in_pixel_rgb    (in_pixel_rgb),
    .in_frame_phase  (in_frame_phase),
    .in_end_of_frame (in_end_of_frame),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rgb         (out_rgb)
  );

  always #6 clk = ~clk;

  // Shadow state of the blur engine
  logic [WORD_W-1:0]  frame_hist [0:HIST_DEPTH*PIXELS-1];
  logic [WORD_W-1:0]  sum_mem    [0:PIXELS-1];
  logic [RGB_W-1:0]   held_mem   [0:PIXELS-1];
  logic [SLOT_W-1:0]  slot_shadow;
  logic               mode_shadow;

  logic [RGB_W-1:0]   blur_expect_q [$];
  int                 fail_count;
  int                 cycle_count;
  int                 items_sent;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  // Pixels that have been seeded by a reinit item; only these are read back
  bit                 px_live [0:PIXELS-1];
  logic [IDX_W-1:0]   live_idx [$];

  // Widen a pixel into the accumulation format
  function automatic logic [WORD_W-1:0] widen_pixel(input logic [RGB_W-1:0] c);
    logic [WORD_W-1:0] w;
    w        = '0;
    w[7:0]   = c[7:0];
    w[18:11] = c[15:8];
    w[28:24] = c[23:19];
    return w;
  endfunction

  // Sum of eight widened pixels back to byte layout
  function automatic logic [RGB_W-1:0] average_of_eight(input logic [WORD_W-1:0] s);
    logic [RGB_W-1:0] c;
    c[7:0]   = s[10:3];
    c[15:8]  = s[21:14];
    c[23:16] = s[31:24];
    return c;
  endfunction

  // Blurred output of one item; updates the shadow state
  function automatic logic [RGB_W-1:0] predict_blur(input logic req,
                                                    input logic [IDX_W-1:0] idx,
                                                    input logic [RGB_W-1:0] rgb,
                                                    input logic [PHASE_W-1:0] phase,
                                                    input logic eof);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] s;
    logic [RGB_W-1:0]  res;
    int                pos;
    w   = widen_pixel(rgb);
    res = rgb;
    if (req == REQ_REINIT) begin
      if (idx < PIXELS) begin
        for (int k = 0; k < HIST_DEPTH; k++) frame_hist[k*PIXELS + idx] = w;
        sum_mem[idx]  = w << 3;
        held_mem[idx] = rgb;
      end
      slot_shadow = '0;
    end else begin
      if (idx < PIXELS) begin
        pos             = slot_shadow * PIXELS + idx;
        s               = sum_mem[idx] - frame_hist[pos] + w;
        frame_hist[pos] = w;
        sum_mem[idx]    = s;
        if (mode_shadow == MODE_CONTINUOUS) begin
          res = average_of_eight(s);
        end else begin
          if (phase == PHASE_REFRESH) held_mem[idx] = average_of_eight(s);
          res = held_mem[idx];
        end
      end
      if (eof) slot_shadow = slot_shadow + 1'b1;
    end
    return res;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("eight_frame_motion_blur verification failed");
      $finish;
    end
  end

  // Receiver with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on accepted items, check each accepted result
  always @(posedge clk) begin
    logic [RGB_W-1:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) mode_shadow = cfg_blur_mode;
      if (in_valid && in_ready)
        blur_expect_q.push_back(predict_blur(in_req_type, in_pixel_index, in_pixel_rgb,
                                             in_frame_phase, in_end_of_frame));
      if (out_valid && out_ready) begin
        if (blur_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] result with nothing expected: out_rgb %06h", $realtime, out_rgb);
        end else begin
          want = blur_expect_q.pop_front();
          if (out_rgb !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("[%0t] out_rgb mismatch: expected %06h actual %06h",
                       $realtime, want, out_rgb);
          end
        end
      end
    end
  end

  // Send one pixel item, with random idle cycles ahead of it
  task automatic send_pixel(input logic req, input logic [IDX_W-1:0] idx,
                            input logic [RGB_W-1:0] rgb, input logic [PHASE_W-1:0] phase,
                            input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_pixel_index  <= idx;
    in_pixel_rgb    <= rgb;
    in_frame_phase  <= phase;
    in_end_of_frame <= eof;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (req == REQ_REINIT && !px_live[idx]) begin
      px_live[idx] = 1'b1;
      live_idx.push_back(idx);
    end
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic set_blur_mode(input logic mode);
    wait_idle();
    cfg_blur_mode <= mode;
    cfg_valid     <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RGB_W-1:0] pick_rgb();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return RGB_W'($urandom_range(24'hffffff));
    endcase
  endfunction

  // Seed npix random pixels, then play nframes well-formed frames over them
  task automatic run_frames(input int nframes, input int npix);
    logic [IDX_W-1:0]   px [$];
    logic [PHASE_W-1:0] base;
    base = PHASE_W'($urandom_range(7));
    repeat (npix) begin
      px.push_back(IDX_W'($urandom_range(16'hffff)));
      send_pixel(REQ_REINIT, px[$], pick_rgb(), PHASE_W'($urandom_range(7)),
                 1'($urandom_range(1)));
    end
    for (int f = 0; f < nframes; f++)
      for (int p = 0; p < npix; p++)
        send_pixel(REQ_NORMAL, px[p], pick_rgb(), base + f[PHASE_W-1:0], p == npix - 1);
  endtask

  // Stray items: random phases, end-of-frame flags and reinits mid-stream
  task automatic send_noise(input int n);
    repeat (n) begin
      if ($urandom_range(4) == 0)
        send_pixel(REQ_REINIT, IDX_W'($urandom_range(16'hffff)), pick_rgb(),
                   PHASE_W'($urandom_range(7)), 1'($urandom_range(1)));
      else
        send_pixel(REQ_NORMAL, live_idx[$urandom_range(live_idx.size() - 1)], pick_rgb(),
                   PHASE_W'($urandom_range(7)), $urandom_range(3) == 0);
    end
  endtask

  // Reinit at the index and colour extremes; end of frame ignored on reinit
  task automatic test_reinit_extremes();
    send_pixel(REQ_REINIT, 16'h0000, 24'h000000, 3'd0, 1'b0);
    send_pixel(REQ_REINIT, 16'hffff, 24'hffffff, 3'd7, 1'b1);
    send_pixel(REQ_REINIT, 16'h5555, 24'ha5a5a5, 3'd2, 1'b0);
    send_pixel(REQ_REINIT, 16'haaaa, 24'h5a5a5a, 3'd5, 1'b1);
  endtask

  // Discrete mode: held colour refreshes only on phase zero
  task automatic test_held_discrete();
    send_pixel(REQ_NORMAL, 16'h0000, 24'hffffff, PHASE_REFRESH, 1'b0);
    send_pixel(REQ_NORMAL, 16'h0000, 24'h000000, 3'd5, 1'b0);
    send_pixel(REQ_NORMAL, 16'hffff, 24'h000000, 3'd3, 1'b0);
    send_pixel(REQ_NORMAL, 16'hffff, 24'h000000, PHASE_REFRESH, 1'b1);
  endtask

  // History slot walks all eight entries and wraps; a reinit clears it
  task automatic test_slot_wrap_and_clear();
    for (int k = 0; k < 9; k++)
      send_pixel(REQ_NORMAL, 16'h5555, pick_rgb(), k[PHASE_W-1:0], 1'b1);
    send_pixel(REQ_NORMAL, 16'h5555, 24'h123456, 3'd1, 1'b1);
    send_pixel(REQ_REINIT, 16'haaaa, 24'hf0f0f0, 3'd4, 1'b0);
    send_pixel(REQ_NORMAL, 16'haaaa, 24'h0f0f0f, PHASE_REFRESH, 1'b0);
  endtask

  task automatic test_continuous_frames();
    set_blur_mode(MODE_CONTINUOUS);
    run_frames(8, 4);
    run_frames(12, 3);
    run_frames(16, 2);
    run_frames(9, 1);
  endtask

  task automatic test_discrete_frames();
    set_blur_mode(MODE_DISCRETE);
    run_frames(16, 4);
    run_frames(10, 5);
    run_frames(8, 2);
  endtask

  // Mostly frame sequences, with noise bursts in between
  task automatic test_mixed_traffic(input logic mode, input int n_items);
    int stop_at;
    set_blur_mode(mode);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) run_frames($urandom_range(12, 8), $urandom_range(5, 1));
      else send_noise($urandom_range(20, 5));
    end
  endtask

  initial begin
    fail_count      = 0;
    cycle_count     = 0;
    items_sent      = 0;
    mode_shadow     = MODE_DISCRETE;
    slot_shadow     = '0;
    send_idle_pct   = 25;
    recv_idle_pct   = 45;
    rst_n           <= 1'b0;
    out_ready       <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_blur_mode   <= MODE_DISCRETE;
    in_valid        <= 1'b0;
    in_req_type     <= REQ_NORMAL;
    in_pixel_index  <= '0;
    in_pixel_rgb    <= '0;
    in_frame_phase  <= '0;
    in_end_of_frame <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles more lightly than the receiver
    test_reinit_extremes();
    test_held_discrete();
    test_slot_wrap_and_clear();
    test_continuous_frames();

    // receiver idles more lightly than the sender
    send_idle_pct = 45;
    recv_idle_pct = 25;
    test_discrete_frames();
    test_mixed_traffic(MODE_CONTINUOUS, 140);

    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_mixed_traffic(MODE_DISCRETE, 140);
    test_mixed_traffic(MODE_CONTINUOUS, 140);

    wait_idle();
    if (fail_count == 0 && blur_expect_q.size() == 0) begin
      $display("eight_frame_motion_blur verification clean");
    end else begin
      $display("eight_frame_motion_blur verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/efmb_pkg.sv
rtl/efmb_front.sv
rtl/efmb_queue.sv
rtl/efmb_back.sv
rtl/eight_frame_motion_blur.sv
tb/sv/tb_eight_frame_motion_blur.sv
